[rtl/tshr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tshr_pkg;
   localparam int DEPTH_DEFAULT = 64;
   localparam int ALPHA_BITS_DEFAULT = 16;
   localparam int FRAME_W = 48 + 24 + 1 + 16 + 32 + 32 + 16 + 48 + 48;

   typedef enum logic [2:0] {
      REQ_PUBLISH = 3'd0,
      REQ_OLDEST  = 3'd1,
      REQ_NEAREST = 3'd2,
      REQ_INTERP  = 3'd3,
      REQ_CLEAR   = 3'd4
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_ISSUE, ST_RD_WAIT, ST_SCAN, ST_SCAN_WAIT, ST_LOAD_A, ST_LOAD_B,
      ST_DIV, ST_LERP, ST_DONE
   } state_type;

   typedef struct packed {
      logic [47:0] t;
      logic [23:0] per;
      logic        ok;
      logic [15:0] gconf;
      logic [31:0] norm;
      logic [31:0] pix;
      logic [15:0] hconf;
      logic [47:0] pos;
      logic [47:0] rot;
   } frame_type;
endpackage
`default_nettype wire

[rtl/tshr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tshr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [47:0] sample_time;
   logic [23:0] frame_period;
   logic        gaze_ok;
   logic [15:0] gaze_conf;
   logic [31:0] gaze_norm_xy;
   logic [31:0] gaze_pixel_xy;
   logic [15:0] head_conf;
   logic [47:0] head_pos_xyz;
   logic [47:0] head_rot_pyr;
   modport source (output valid, req_type, sample_time, frame_period, gaze_ok, gaze_conf,
      gaze_norm_xy, gaze_pixel_xy, head_conf, head_pos_xyz, head_rot_pyr, input ready);
   modport sink (input valid, req_type, sample_time, frame_period, gaze_ok, gaze_conf,
      gaze_norm_xy, gaze_pixel_xy, head_conf, head_pos_xyz, head_rot_pyr, output ready);
endinterface

interface tshr_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [47:0] out_time;
   logic [23:0] out_period;
   logic        out_gaze_ok;
   logic [15:0] out_gaze_conf;
   logic [31:0] out_gaze_norm;
   logic [31:0] out_gaze_pixel;
   logic [15:0] out_head_conf;
   logic [47:0] out_head_pos;
   logic [47:0] out_head_rot;
   logic [6:0]  fill_percent;
   logic [31:0] frames_published;
   modport source (output valid, hit, out_time, out_period, out_gaze_ok, out_gaze_conf,
      out_gaze_norm, out_gaze_pixel, out_head_conf, out_head_pos, out_head_rot,
      fill_percent, frames_published, input ready);
   modport sink (input valid, hit, out_time, out_period, out_gaze_ok, out_gaze_conf,
      out_gaze_norm, out_gaze_pixel, out_head_conf, out_head_pos, out_head_rot,
      fill_percent, frames_published, output ready);
endinterface
`default_nettype wire

[rtl/tshr_lerp.sv]
`timescale 1ns / 1ps
`default_nettype none
// one field step: a + s * floor(|b-a| * alpha / 2^ab), 48-bit magnitude split in two halves
module tshr_lerp #(
   parameter int ALPHA_BITS = tshr_pkg::ALPHA_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  start,
   input  wire logic [47:0]           a,
   input  wire logic [47:0]           b,
   input  wire logic [ALPHA_BITS:0]   alpha,
   output logic                       done,
   output logic [47:0]                y
);
   import tshr_pkg::*;
   logic [1:0]  phase_ff, phase_in;
   logic [47:0] mag_ff, mag_in, a_ff, a_in, acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [ALPHA_BITS+24:0] prod;
   logic [71:0] wide;

   always_comb begin
      prod = (phase_ff == 2'd1 ? {1'b0, mag_ff[47:24]} : {1'b0, mag_ff[23:0]}) * alpha;
      phase_in = phase_ff;
      mag_in = mag_ff;
      a_in = a_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      wide = '0;
      done = 1'b0;
      if (start) begin
         phase_in = 2'd1;
         a_in = a;
         neg_in = b < a;
         mag_in = (b < a) ? a - b : b - a;
      end else if (phase_ff == 2'd1) begin
         wide = 72'(prod) << 24;
         acc_in = 48'(wide >> ALPHA_BITS);
         phase_in = 2'd2;
      end else if (phase_ff == 2'd2) begin
         acc_in = acc_ff + 48'(prod >> ALPHA_BITS);
         phase_in = 2'd3;
      end else if (phase_ff == 2'd3) begin
         done = 1'b1;
         phase_in = 2'd0;
      end
      y = neg_ff ? a_ff - acc_ff : a_ff + acc_ff;
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      mag_ff <= mag_in;
      a_ff <= a_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
   end
endmodule
`default_nettype wire

[rtl/timestamped_sample_history_ring_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ring of DEPTH frame slots holding up to DEPTH-1 frames; a publish onto a full ring drops
// the oldest. One request at a time. Nearest scans the stored frames through one memory
// read port, and interpolate runs the one-bit-a-cycle alpha divider and a shared lerp
// unit that walks fields and lanes one at a time. interp_enable sits at address 0.
module timestamped_sample_history_ring_unit #(
   parameter int DEPTH = tshr_pkg::DEPTH_DEFAULT,
   parameter int ALPHA_BITS = tshr_pkg::ALPHA_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tshr_req_if.sink   req,
   tshr_rsp_if.source rsp,
   input  wire logic  csr_psel,
   input  wire logic  csr_penable,
   input  wire logic  csr_pwrite,
   input  wire logic  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tshr_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int FW = CW + 7;
   localparam int FS = FW + AW;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [ALPHA_BITS:0] ONE = (ALPHA_BITS+1)'(1) << ALPHA_BITS;
   localparam logic [ALPHA_BITS:0] HALF = (ALPHA_BITS+1)'(1) << (ALPHA_BITS - 1);
   // reciprocal of DEPTH, exact floor for every fill count
   localparam logic [FS:0] FILL_MUL =
      (FS+1)'(((64'd1 << FS) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

   frame_type mem [DEPTH];
   frame_type rd_ff, fa_ff, fa_in, fb_ff, fb_in, res_ff, res_in;
   logic [AW-1:0] rd_addr;
   logic rd_en;
   logic [AW-1:0] wr_ff, wr_in, rs_ff, rs_in, scan_ff, scan_in;
   logic [31:0] pub_ff, pub_in;
   logic en_ff;
   state_type state_ff, state_in;
   logic [47:0] tgt_ff, tgt_in, best_ff, best_in;
   logic found_ff, found_in, hit_ff, hit_in;
   logic [47:0] rem_ff, rem_in, den_ff, den_in;
   logic [ALPHA_BITS:0] q_ff, q_in;
   logic [$clog2(ALPHA_BITS+1)-1:0] dcnt_ff, dcnt_in;
   logic [3:0] fld_ff, fld_in;
   logic busy_ff, busy_in;
   logic lstart;
   logic [47:0] la, lb, ly;
   logic ldone;
   logic vld_ff, vld_in;
   logic [CW-1:0] cnt;
   logic [FW-1:0] fill_w;
   logic [FW+FS:0] fill_p;
   logic [47:0] t_gap;
   logic [48:0] rem2;
   logic gblend, hblend;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {31'd0, en_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) en_ff <= 1'b1;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0) en_ff <= csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.req_type == REQ_PUBLISH) begin
         mem[wr_ff] <= '{req.sample_time, req.frame_period, req.gaze_ok, req.gaze_conf,
            req.gaze_norm_xy, req.gaze_pixel_xy, req.head_conf, req.head_pos_xyz,
            req.head_rot_pyr};
      end
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   tshr_lerp #(.ALPHA_BITS(ALPHA_BITS)) u_lerp (
      .clock(clock), .start(lstart), .a(la), .b(lb), .alpha(q_ff), .done(ldone), .y(ly));

   always_comb begin
      cnt = (wr_ff >= rs_ff) ? CW'(wr_ff - rs_ff) : CW'(DEPTH) - CW'(rs_ff - wr_ff);
      fill_w = FW'(cnt) * FW'(100);
      fill_p = (FW+FS+1)'(fill_w) * (FW+FS+1)'(FILL_MUL);
      gblend = fa_ff.ok && fb_ff.ok;
      hblend = fa_ff.hconf != 16'd0 && fb_ff.hconf != 16'd0;
      t_gap = (rd_ff.t >= tgt_ff) ? rd_ff.t - tgt_ff : tgt_ff - rd_ff.t;
      rem2 = {rem_ff, 1'b0};
      la = '0;
      lb = '0;
      unique case (fld_ff)
         4'd0: begin la = fa_ff.t; lb = fb_ff.t; end
         4'd1: begin la = 48'(fa_ff.per); lb = 48'(fb_ff.per); end
         4'd2: begin la = 48'(fa_ff.gconf); lb = 48'(fb_ff.gconf); end
         4'd3: begin la = 48'(fa_ff.norm[15:0]); lb = 48'(fb_ff.norm[15:0]); end
         4'd4: begin la = 48'(fa_ff.norm[31:16]); lb = 48'(fb_ff.norm[31:16]); end
         4'd5: begin la = 48'(fa_ff.pix[15:0]); lb = 48'(fb_ff.pix[15:0]); end
         4'd6: begin la = 48'(fa_ff.pix[31:16]); lb = 48'(fb_ff.pix[31:16]); end
         4'd7: begin la = 48'(fa_ff.hconf); lb = 48'(fb_ff.hconf); end
         4'd8: begin la = 48'(fa_ff.pos[15:0] ^ 16'h8000); lb = 48'(fb_ff.pos[15:0] ^ 16'h8000); end
         4'd9: begin la = 48'(fa_ff.pos[31:16] ^ 16'h8000); lb = 48'(fb_ff.pos[31:16] ^ 16'h8000); end
         4'd10: begin la = 48'(fa_ff.pos[47:32] ^ 16'h8000); lb = 48'(fb_ff.pos[47:32] ^ 16'h8000); end
         4'd11: begin la = 48'(fa_ff.rot[15:0] ^ 16'h8000); lb = 48'(fb_ff.rot[15:0] ^ 16'h8000); end
         4'd12: begin la = 48'(fa_ff.rot[31:16] ^ 16'h8000); lb = 48'(fb_ff.rot[31:16] ^ 16'h8000); end
         4'd13: begin la = 48'(fa_ff.rot[47:32] ^ 16'h8000); lb = 48'(fb_ff.rot[47:32] ^ 16'h8000); end
         default: begin la = '0; lb = '0; end
      endcase

      state_in = state_ff;
      tgt_in = tgt_ff; best_in = best_ff; found_in = found_ff;
      hit_in = hit_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff; dcnt_in = dcnt_ff;
      fld_in = fld_ff; busy_in = busy_ff; fa_in = fa_ff; fb_in = fb_ff; res_in = res_ff;
      wr_in = wr_ff; rs_in = rs_ff; pub_in = pub_ff; scan_in = scan_ff; vld_in = vld_ff;
      rd_en = 1'b0; rd_addr = scan_ff; lstart = 1'b0;
      req.ready = (state_ff == ST_IDLE) && !vld_ff;
      if (rsp.valid && rsp.ready) vld_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               tgt_in = req.sample_time;
               res_in = '0;
               hit_in = 1'b0;
               found_in = 1'b0;
               scan_in = rs_ff;
               state_in = ST_DONE;
               if (req.req_type == REQ_PUBLISH) begin
                  res_in = '{req.sample_time, req.frame_period, req.gaze_ok, req.gaze_conf,
                     req.gaze_norm_xy, req.gaze_pixel_xy, req.head_conf, req.head_pos_xyz,
                     req.head_rot_pyr};
                  hit_in = 1'b1;
                  wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
                  if (wr_in == rs_ff) rs_in = (rs_ff == LAST) ? '0 : rs_ff + 1'b1;
                  pub_in = pub_ff + 32'd1;
               end else if (req.req_type == REQ_CLEAR) begin
                  wr_in = '0; rs_in = '0; pub_in = '0;
               end else if (cnt != '0 && (req.req_type == REQ_OLDEST ||
                            req.req_type == REQ_NEAREST || req.req_type == REQ_INTERP)) begin
                  hit_in = 1'b1;
                  if (req.req_type == REQ_NEAREST) state_in = ST_SCAN;
                  else if (req.req_type == REQ_OLDEST) state_in = ST_RD_ISSUE;
                  else begin
                     scan_in = (wr_ff == '0) ? LAST : wr_ff - 1'b1;
                     if (en_ff && cnt >= CW'(2)) begin
                        scan_in = (scan_in == '0) ? LAST : scan_in - 1'b1;
                        state_in = ST_LOAD_A;
                     end else state_in = ST_RD_ISSUE;
                  end
               end
            end
         end
         ST_RD_ISSUE: begin rd_en = 1'b1; state_in = ST_RD_WAIT; end
         ST_RD_WAIT: begin res_in = rd_ff; state_in = ST_DONE; end
         ST_SCAN: begin
            if (scan_ff == wr_ff) state_in = ST_DONE;
            else begin rd_en = 1'b1; state_in = ST_SCAN_WAIT; end
         end
         ST_SCAN_WAIT: begin
            if (!found_ff || t_gap < best_ff) begin
               best_in = t_gap; found_in = 1'b1; res_in = rd_ff;
            end
            scan_in = (scan_ff == LAST) ? '0 : scan_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_LOAD_A: begin
            // two-phase read: issue older, then capture it; ST_LOAD_B does the same for newer
            if (!busy_ff) begin rd_en = 1'b1; busy_in = 1'b1; end
            else begin
               fa_in = rd_ff;
               scan_in = (scan_ff == LAST) ? '0 : scan_ff + 1'b1;
               busy_in = 1'b0;
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            if (!busy_ff) begin rd_en = 1'b1; busy_in = 1'b1; end
            else begin
               fb_in = rd_ff;
               busy_in = 1'b0;
               dcnt_in = '0;
               q_in = '0;
               rem_in = tgt_ff - fa_ff.t;
               den_in = rd_ff.t - fa_ff.t;
               state_in = ST_LERP;
               fld_in = 4'd0;
               if (rd_ff.t <= fa_ff.t) q_in = HALF;
               else if (tgt_ff <= fa_ff.t) q_in = '0;
               else if (tgt_ff >= rd_ff.t) q_in = ONE;
               else state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            q_in = {q_ff[ALPHA_BITS-1:0], 1'b0};
            rem_in = rem2[47:0];
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = 48'(rem2 - {1'b0, den_ff});
               q_in[0] = 1'b1;
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == ($bits(dcnt_ff))'(ALPHA_BITS - 1)) state_in = ST_LERP;
         end
         ST_LERP: begin
            if ((fld_ff >= 4'd2 && fld_ff <= 4'd6 && !gblend) ||
                (fld_ff >= 4'd7 && fld_ff <= 4'd13 && !hblend)) begin
               fld_in = fld_ff + 1'b1;
            end else if (fld_ff == 4'd14) begin
               if (!gblend) begin
                  res_in.ok = fa_ff.ok ? fa_ff.ok : fb_ff.ok;
                  res_in.gconf = fa_ff.ok ? fa_ff.gconf : fb_ff.gconf;
                  res_in.norm = fa_ff.ok ? fa_ff.norm : fb_ff.norm;
                  res_in.pix = fa_ff.ok ? fa_ff.pix : fb_ff.pix;
               end else res_in.ok = 1'b1;
               if (!hblend) begin
                  res_in.hconf = (fa_ff.hconf > fb_ff.hconf) ? fa_ff.hconf : fb_ff.hconf;
                  res_in.pos = (fa_ff.hconf > fb_ff.hconf) ? fa_ff.pos : fb_ff.pos;
                  res_in.rot = (fa_ff.hconf > fb_ff.hconf) ? fa_ff.rot : fb_ff.rot;
               end
               state_in = ST_DONE;
            end else if (!busy_ff) begin
               lstart = 1'b1; busy_in = 1'b1;
            end else if (ldone) begin
               busy_in = 1'b0;
               fld_in = fld_ff + 1'b1;
               unique case (fld_ff)
                  4'd0: res_in.t = ly;
                  4'd1: res_in.per = ly[23:0];
                  4'd2: res_in.gconf = ly[15:0];
                  4'd3: res_in.norm[15:0] = ly[15:0];
                  4'd4: res_in.norm[31:16] = ly[15:0];
                  4'd5: res_in.pix[15:0] = ly[15:0];
                  4'd6: res_in.pix[31:16] = ly[15:0];
                  4'd7: res_in.hconf = ly[15:0];
                  4'd8: res_in.pos[15:0] = ly[15:0] ^ 16'h8000;
                  4'd9: res_in.pos[31:16] = ly[15:0] ^ 16'h8000;
                  4'd10: res_in.pos[47:32] = ly[15:0] ^ 16'h8000;
                  4'd11: res_in.rot[15:0] = ly[15:0] ^ 16'h8000;
                  4'd12: res_in.rot[31:16] = ly[15:0] ^ 16'h8000;
                  4'd13: res_in.rot[47:32] = ly[15:0] ^ 16'h8000;
                  default: res_in.t = res_ff.t;
               endcase
            end
         end
         ST_DONE: begin vld_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; wr_ff <= '0; rs_ff <= '0; pub_ff <= '0;
         vld_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in; wr_ff <= wr_in; rs_ff <= rs_in; pub_ff <= pub_in;
         vld_ff <= vld_in; busy_ff <= busy_in;
      end
      tgt_ff <= tgt_in; best_ff <= best_in; found_ff <= found_in;
      hit_ff <= hit_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
      dcnt_ff <= dcnt_in; fld_ff <= fld_in; fa_ff <= fa_in; fb_ff <= fb_in;
      res_ff <= res_in; scan_ff <= scan_in;
   end

   assign rsp.valid = vld_ff;
   assign rsp.hit = hit_ff;
   assign rsp.out_time = res_ff.t;
   assign rsp.out_period = res_ff.per;
   assign rsp.out_gaze_ok = res_ff.ok;
   assign rsp.out_gaze_conf = res_ff.gconf;
   assign rsp.out_gaze_norm = res_ff.norm;
   assign rsp.out_gaze_pixel = res_ff.pix;
   assign rsp.out_head_conf = res_ff.hconf;
   assign rsp.out_head_pos = res_ff.pos;
   assign rsp.out_head_rot = res_ff.rot;
   assign rsp.fill_percent = 7'(fill_p >> FS);
   assign rsp.frames_published = pub_ff;
endmodule
`default_nettype wire

[rtl/tshr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module tshr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [2:0] req_type,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit,
   input wire logic [6:0] rsp_fill_percent,
   input wire logic [31:0] rsp_frames_published
);
   import tshr_pkg::*;
   // no new beat taken while a result waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted with result pending");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_percent <= 7'd100) else $error("fill above 100");
   a_pub_hit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_PUBLISH) |=> ##1 (rsp_valid && rsp_hit))
      else $error("publish without hit");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_CLEAR) |=> ##1
      (rsp_valid && !rsp_hit && rsp_frames_published == 32'd0))
      else $error("clear result wrong");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule

bind timestamped_sample_history_ring_unit tshr_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .req_type(req.req_type), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_hit(rsp.hit), .rsp_fill_percent(rsp.fill_percent),
   .rsp_frames_published(rsp.frames_published));
`default_nettype wire

[tb/ring_checker.sv]
`timescale 1ns / 1ps
module ring_checker #(
   parameter int DEPTH = 64,
   parameter int ALPHA_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tshr_req_if       req,
   tshr_rsp_if       rsp,
   input  wire logic interp_on,
   output int        fail_count,
   output int        pending
);
   import tshr_pkg::*;

   frame_type ring_mem [DEPTH];
   int unsigned wr_slot, rd_slot;
   logic [31:0] pub_total;

   typedef struct packed {
      logic      hit;
      frame_type fr;
      logic [6:0] fill;
      logic [31:0] pubs;
   } answer_type;

   answer_type answers [$];

   function automatic int unsigned held_frames();
      return (wr_slot + DEPTH - rd_slot) % DEPTH;
   endfunction

   function automatic logic [63:0] scaled_step(logic [63:0] mag, logic [63:0] alpha);
      logic [127:0] p;
      p = mag * alpha;
      return 64'(p >> ALPHA_BITS);
   endfunction

   function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] alpha);
      if (b >= a) return a + scaled_step(b - a, alpha);
      return a - scaled_step(a - b, alpha);
   endfunction

   function automatic logic [47:0] blend_lanes(logic [47:0] a, logic [47:0] b, int lanes,
                                               bit sgn, logic [63:0] alpha);
      logic [47:0] r;
      logic [15:0] x, y, z, off;
      r = '0;
      off = sgn ? 16'h8000 : 16'h0;
      for (int i = 0; i < lanes; i++) begin
         x = a[16*i +: 16] ^ off;
         y = b[16*i +: 16] ^ off;
         z = 16'(blend(64'(x), 64'(y), alpha));
         r[16*i +: 16] = z ^ off;
      end
      return r;
   endfunction

   function automatic logic [63:0] alpha_of(logic [47:0] target, logic [47:0] t_old,
                                            logic [47:0] t_new);
      logic [127:0] num;
      if (t_new <= t_old) return 64'd1 << (ALPHA_BITS - 1);
      if (target <= t_old) return 64'd0;
      if (target >= t_new) return 64'd1 << ALPHA_BITS;
      num = {80'd0, target - t_old} << ALPHA_BITS;
      return 64'(num / (t_new - t_old));
   endfunction

   function automatic answer_type serve_request(input req_code_type kind, input frame_type inf);
      answer_type r;
      frame_type a, b, f;
      logic [63:0] al, t_gap, best;
      int unsigned s, ns;
      r = '0;
      f = '0;
      case (kind)
         REQ_PUBLISH: begin
            f = inf;
            ring_mem[wr_slot] = inf;
            if ((wr_slot + 1) % DEPTH == rd_slot) rd_slot = (rd_slot + 1) % DEPTH;
            wr_slot = (wr_slot + 1) % DEPTH;
            pub_total++;
            r.hit = 1;
         end
         REQ_CLEAR: begin
            wr_slot = 0;
            rd_slot = 0;
            pub_total = 0;
         end
         REQ_OLDEST, REQ_NEAREST, REQ_INTERP: if (held_frames() != 0) begin
            r.hit = 1;
            if (kind == REQ_OLDEST) begin
               f = ring_mem[rd_slot];
            end else if (kind == REQ_NEAREST) begin
               s = rd_slot;
               best = '1;
               while (s != wr_slot) begin
                  t_gap = 64'(ring_mem[s].t >= inf.t ? ring_mem[s].t - inf.t :
                              inf.t - ring_mem[s].t);
                  if (s == rd_slot || t_gap < best) begin
                     best = t_gap;
                     f = ring_mem[s];
                  end
                  s = (s + 1) % DEPTH;
               end
            end else begin
               ns = (wr_slot + DEPTH - 1) % DEPTH;
               if (interp_on && held_frames() >= 2) begin
                  a = ring_mem[(ns + DEPTH - 1) % DEPTH];
                  b = ring_mem[ns];
                  al = alpha_of(inf.t, a.t, b.t);
                  if (a.ok && b.ok) begin
                     f.ok = 1;
                     f.gconf = 16'(blend(64'(a.gconf), 64'(b.gconf), al));
                     f.norm = 32'(blend_lanes(48'(a.norm), 48'(b.norm), 2, 0, al));
                     f.pix = 32'(blend_lanes(48'(a.pix), 48'(b.pix), 2, 0, al));
                  end else begin
                     b = a.ok ? a : b;
                     f.ok = b.ok; f.gconf = b.gconf; f.norm = b.norm; f.pix = b.pix;
                     b = ring_mem[ns];
                  end
                  if (a.hconf != 0 && b.hconf != 0) begin
                     f.hconf = 16'(blend(64'(a.hconf), 64'(b.hconf), al));
                     f.pos = blend_lanes(a.pos, b.pos, 3, 1, al);
                     f.rot = blend_lanes(a.rot, b.rot, 3, 1, al);
                  end else begin
                     if (a.hconf > b.hconf) b = a;
                     f.hconf = b.hconf; f.pos = b.pos; f.rot = b.rot;
                  end
                  f.t = 48'(blend(64'(a.t), 64'(ring_mem[ns].t), al));
                  f.per = 24'(blend(64'(a.per), 64'(ring_mem[ns].per), al));
               end else begin
                  f = ring_mem[ns];
               end
            end
         end
         default: ;
      endcase
      r.fr = f;
      r.fill = 7'(held_frames() * 100 / DEPTH);
      r.pubs = pub_total;
      return r;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      frame_type inf, got;
      answer_type want;
      if (reset) begin
         wr_slot <= 0;
         rd_slot <= 0;
         pub_total <= 0;
         fail_count <= 0;
         answers.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = {rsp.out_time, rsp.out_period, rsp.out_gaze_ok, rsp.out_gaze_conf,
                   rsp.out_gaze_norm, rsp.out_gaze_pixel, rsp.out_head_conf,
                   rsp.out_head_pos, rsp.out_head_rot};
            if (answers.size() == 0) begin
               $display("%0t: unexpected result beat", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (rsp.hit !== want.hit || got !== want.fr || rsp.fill_percent !== want.fill ||
                   rsp.frames_published !== want.pubs) begin
                  $display("%0t: mismatch expected hit=%0b fill=%0d pubs=%0d frame=%h",
                           $realtime, want.hit, want.fill, want.pubs, want.fr);
                  $display("%0t:          actual   hit=%0b fill=%0d pubs=%0d frame=%h",
                           $realtime, rsp.hit, rsp.fill_percent, rsp.frames_published, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready) begin
            inf = {req.sample_time, req.frame_period, req.gaze_ok, req.gaze_conf,
                   req.gaze_norm_xy, req.gaze_pixel_xy, req.head_conf, req.head_pos_xyz,
                   req.head_rot_pyr};
            answers.push_back(serve_request(req_code_type'(req.req_type), inf));
         end
      end
   end
endmodule

[tb/timestamped_sample_history_ring_unit_tb.sv]
`timescale 1ns / 1ps
module timestamped_sample_history_ring_unit_tb;
   import tshr_pkg::*;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic interp_on;
   logic hold_long;
   int fail_count, pending;

   tshr_req_if req ();
   tshr_rsp_if rsp ();

   timestamped_sample_history_ring_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ring_checker #(.DEPTH(DEPTH_DEFAULT), .ALPHA_BITS(ALPHA_BITS_DEFAULT)) checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .interp_on(interp_on),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // result side: random stalls plus one long hold-off
   initial begin
      int g;
      rsp.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_long) begin
            rsp.ready <= 0;
            repeat (3000) @(posedge clock);
            hold_long = 0;
         end
         rsp.ready <= 1;
         @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp.ready <= 0;
            repeat (g) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1; csr_paddr <= 0; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      interp_on = value[0];
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send(req_code_type kind, logic [47:0] t, bit rand_body, bit lively);
      int g;
      req.valid <= 1;
      req.req_type <= kind;
      req.sample_time <= t;
      req.frame_period <= 24'($urandom);
      req.gaze_ok <= rand_body ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
      req.gaze_conf <= 16'($urandom);
      req.gaze_norm_xy <= $urandom;
      req.gaze_pixel_xy <= $urandom;
      req.head_conf <= $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
      req.head_pos_xyz <= 48'({$urandom, $urandom});
      req.head_rot_pyr <= 48'({$urandom, $urandom});
      @(posedge clock iff req.ready);
      g = lively ? 0 : gap_len();
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   logic [47:0] clock_us;

   function automatic logic [47:0] pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '1;
      if (r == 1) return 0;
      if (r < 4) return 48'({$urandom, $urandom});
      return 48'(clock_us + 48'($urandom_range(0, 400)) - 48'd300);
   endfunction

   initial begin
      int r;
      req_code_type kind;
      reset = 1;
      hold_long = 0;
      interp_on = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      req.valid = 0; req.req_type = REQ_PUBLISH; req.sample_time = 0; req.frame_period = 0;
      req.gaze_ok = 0; req.gaze_conf = 0; req.gaze_norm_xy = 0; req.gaze_pixel_xy = 0;
      req.head_conf = 0; req.head_pos_xyz = 0; req.head_rot_pyr = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty queries, extremes, equal and reversed times, unknown codes
      send(REQ_OLDEST, 0, 0, 0);
      send(REQ_NEAREST, '1, 0, 0);
      send(REQ_INTERP, 5, 0, 0);
      send(REQ_PUBLISH, 48'd1000, 0, 0);
      send(REQ_INTERP, 48'd900, 0, 0);
      send(REQ_PUBLISH, 48'd1000, 1, 0);
      send(REQ_INTERP, 48'd1000, 0, 0);
      send(REQ_PUBLISH, 48'd500, 1, 0);
      send(REQ_INTERP, 48'd700, 0, 0);
      send(REQ_PUBLISH, '1, 1, 0);
      send(REQ_PUBLISH, 0, 1, 0);
      send(REQ_NEAREST, 48'd1000, 0, 0);
      send(REQ_NEAREST, '1, 0, 0);
      send(REQ_OLDEST, 0, 0, 0);
      send(REQ_PUBLISH, 48'd2000, 1, 0);
      send(REQ_INTERP, 48'd1, 0, 0);
      send(REQ_INTERP, 48'd1999, 0, 0);
      send(REQ_INTERP, '1, 0, 0);
      send(req_code_type'(3'd5), 0, 0, 0);
      send(req_code_type'(3'd7), '1, 0, 0);
      send(REQ_CLEAR, 0, 0, 0);
      send(REQ_OLDEST, 0, 0, 0);
      drain();

      // random phases over the register setting
      clock_us = 48'd100000;
      for (int phase = 0; phase < 4; phase++) begin
         csr_write(phase[0] ? 32'h0 : 32'hFFFF_FFFF);
         if (phase == 1) hold_long = 1;
         for (int n = 0; n < 360; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) kind = REQ_PUBLISH;
            else if (r < 62) kind = REQ_OLDEST;
            else if (r < 74) kind = REQ_NEAREST;
            else if (r < 96) kind = REQ_INTERP;
            else if (r < 98) kind = REQ_CLEAR;
            else kind = req_code_type'(3'($urandom_range(5, 7)));
            if (kind == REQ_PUBLISH) begin
               r = $urandom_range(0, 19);
               if (r == 0) clock_us = 48'({$urandom, $urandom});
               else if (r == 1) clock_us = clock_us - 48'($urandom_range(0, 50));
               else clock_us = clock_us + 48'($urandom_range(0, 4000));
               send(kind, clock_us, 1, phase == 1);
            end else begin
               send(kind, pick_target(), 1, phase == 1);
            end
         end
         drain();
      end
      csr_write(32'h1);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/tshr_pkg.sv
rtl/tshr_if.sv
rtl/tshr_lerp.sv
rtl/timestamped_sample_history_ring_unit.sv
rtl/tshr_checker.sv
tb/ring_checker.sv
tb/timestamped_sample_history_ring_unit_tb.sv
